[rtl/core/pad_source_index_mapper_macros.svh]
// ---------------------------------------------------------------------------
// pad_source_index_mapper_macros.svh
// Assertion macros for the pad source index mapper checker.
// ---------------------------------------------------------------------------
`ifndef PAD_SOURCE_INDEX_MAPPER_MACROS_SVH
`define PAD_SOURCE_INDEX_MAPPER_MACROS_SVH

// Checked on every rising edge of i_clk while i_rst_n is high.
`define PSIM_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// Checked on every rising edge of i_clk, reset included.
`define PSIM_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

[rtl/core/psim_pkg.sv]
// ---------------------------------------------------------------------------
// psim_pkg
// Shared types and constants of the pad source index mapper.
// ---------------------------------------------------------------------------
package psim_pkg;

    localparam int MAX_DIMS   = 3;
    localparam int NUM_DIMS   = 3;
    localparam int DIMS_USED  = (NUM_DIMS > MAX_DIMS) ? MAX_DIMS :
                                ((NUM_DIMS < 1) ? 1 : NUM_DIMS);
    localparam int FIRST_DIM  = MAX_DIMS - DIMS_USED;

    localparam int COORD_BITS  = 18;
    localparam int IN_FIELD_W  = 18;
    localparam int COORD_USE_W = (COORD_BITS < IN_FIELD_W) ? COORD_BITS : IN_FIELD_W;

    localparam int SIZE_W      = 16;
    localparam int MODE_W      = 2;
    localparam int STRIDE_W    = 2 * SIZE_W;
    localparam int IDX_W       = 48;

    // Signed width that holds a coordinate, left pad plus size, and their differences.
    localparam int MAP_W = ((COORD_USE_W > SIZE_W + 1) ? COORD_USE_W : SIZE_W + 1) + 2;

    // Reflect mode excludes the edge element, hence the offset of two.
    localparam int REFLECT_GAP = 2;

    localparam int IN_TDATA_W  = ((MAX_DIMS * IN_FIELD_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W = IDX_W;
    localparam int OUT_TUSER_W = 2;

    localparam int CFG_ADDR_W  = 3;
    localparam int CFG_DATA_W  = SIZE_W;

    typedef enum logic [MODE_W-1:0] {
        MODE_CONSTANT  = 2'd0,
        MODE_REFLECT   = 2'd1,
        MODE_REPLICATE = 2'd2,
        MODE_CIRCULAR  = 2'd3
    } t_pad_mode;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_PAD_MODE    = 3'd0,
        REG_IN_SIZE_D0  = 3'd1,
        REG_IN_SIZE_D1  = 3'd2,
        REG_IN_SIZE_D2  = 3'd3,
        REG_LEFT_PAD_D0 = 3'd4,
        REG_LEFT_PAD_D1 = 3'd5,
        REG_LEFT_PAD_D2 = 3'd6
    } t_cfg_reg;

    // Result of one dimension lane.
    typedef struct packed {
        logic [SIZE_W-1:0] m;
        logic              fill;
        logic              err;
    } t_lane_res;

endpackage

[rtl/core/psim_lane.sv]
// ---------------------------------------------------------------------------
// psim_lane
// Maps the coordinate of one dimension to its source coordinate.
// ---------------------------------------------------------------------------
module psim_lane (
    input  logic                          i_clk,
    input  logic                          i_load,
    input  logic [psim_pkg::COORD_USE_W-1:0] i_coord,
    input  psim_pkg::t_pad_mode           i_mode,
    input  logic [psim_pkg::SIZE_W-1:0]   i_size,
    input  logic [psim_pkg::SIZE_W-1:0]   i_lpad,
    output psim_pkg::t_lane_res           o_res
);
    import psim_pkg::*;

    localparam logic signed [MAP_W-1:0] REFL = MAP_W'(REFLECT_GAP);

    logic signed [MAP_W-1:0] x;
    logic signed [MAP_W-1:0] l;
    logic signed [MAP_W-1:0] s;
    logic signed [MAP_W-1:0] ls;
    logic signed [MAP_W-1:0] e;
    logic signed [MAP_W-1:0] m;
    logic                    left;
    logic                    right;
    logic                    fill;
    logic                    oob;
    t_lane_res               n_res;
    t_lane_res               r_res;

    assign x     = signed'(MAP_W'(i_coord));
    assign l     = signed'(MAP_W'(i_lpad));
    assign s     = signed'(MAP_W'(i_size));
    assign ls    = l + s;
    assign e     = x - ls;
    assign left  = x < l;
    assign right = !left && (x >= ls);

    always_comb begin
        m = x - l;
        if (left) begin
            case (i_mode)
                MODE_REFLECT:   m = l - x;
                MODE_REPLICATE: m = '0;
                MODE_CIRCULAR:  m = s - (l - x);
                default:        m = '0;
            endcase
        end else if (right) begin
            case (i_mode)
                MODE_REFLECT:   m = s - REFL - e;
                MODE_REPLICATE: m = s - MAP_W'(1);
                MODE_CIRCULAR:  m = e;
                default:        m = '0;
            endcase
        end
    end

    assign fill = (i_mode == MODE_CONSTANT) && (left || right);
    assign oob  = (m < 0) || (m >= s);

    assign n_res.m    = m[SIZE_W-1:0];
    assign n_res.fill = fill;
    assign n_res.err  = !fill && oob;

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= n_res;
        end
    end

    assign o_res = r_res;

endmodule

[rtl/core/psim_merge.sv]
// ---------------------------------------------------------------------------
// psim_merge
// Weights the lane results by their strides and sums them into the index.
// ---------------------------------------------------------------------------
module psim_merge (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_valid,
    output logic                                    o_take,
    input  psim_pkg::t_lane_res [psim_pkg::MAX_DIMS-1:0] i_res,
    input  logic [psim_pkg::MAX_DIMS-1:0][psim_pkg::SIZE_W-1:0] i_size,
    output logic                                    o_valid,
    input  logic                                    i_ready,
    output logic [psim_pkg::IDX_W-1:0]              o_index,
    output logic                                    o_fill,
    output logic                                    o_err
);
    import psim_pkg::*;

    logic [STRIDE_W-1:0] r_stride_outer;
    logic [IDX_W-1:0]    r_p0;
    logic [STRIDE_W-1:0] r_p1;
    logic [SIZE_W-1:0]   r_p2;
    logic                r_fill2;
    logic                r_err2;
    logic                r_v2;
    logic                r_v3;
    logic [IDX_W-1:0]    r_index;
    logic                r_fill;
    logic                r_err;
    logic                load2;
    logic                load3;
    logic [IDX_W-1:0]    sum;

    assign load3  = r_v2 && (!r_v3 || i_ready);
    assign o_take = !r_v2 || load3;
    assign load2  = i_valid && o_take;
    assign sum    = r_p0 + IDX_W'(r_p1) + IDX_W'(r_p2);

    // Stride of the outermost dimension, refreshed every cycle.
    always_ff @(posedge i_clk) begin
        r_stride_outer <= i_size[1] * i_size[2];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (load2) begin
                r_v2 <= 1'b1;
            end else if (load3) begin
                r_v2 <= 1'b0;
            end
            if (load3) begin
                r_v3 <= 1'b1;
            end else if (i_ready) begin
                r_v3 <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load2) begin
            r_p0    <= i_res[0].m * r_stride_outer;
            r_p1    <= i_res[1].m * i_size[2];
            r_p2    <= i_res[2].m;
            r_fill2 <= i_res[0].fill || i_res[1].fill || i_res[2].fill;
            r_err2  <= i_res[0].err || i_res[1].err || i_res[2].err;
        end
        if (load3) begin
            r_index <= (r_fill2 || r_err2) ? '0 : sum;
            r_fill  <= r_fill2 && !r_err2;
            r_err   <= r_err2;
        end
    end

    assign o_valid = r_v3;
    assign o_index = r_index;
    assign o_fill  = r_fill;
    assign o_err   = r_err;

endmodule

[rtl/core/pad_source_index_mapper.sv]
// ---------------------------------------------------------------------------
// pad_source_index_mapper
// Maps an output coordinate of a padded 3-D tensor to its source index.
// ---------------------------------------------------------------------------
// Pipeline: three register stages (lanes, multiply, sum), passed in that
// order by each accepted item on its way to the output port.
// Throughput: one item per cycle unless the output stalls; each stage holds
// one item, and a stage empties into the next as soon as that one moves.
// Reset: synchronous, active low; clears all stage valids and loads the
// register defaults (constant mode, every size 1, every left pad 0).
// ---------------------------------------------------------------------------
module pad_source_index_mapper (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // Configuration write port.
    input  logic                               i_cfg_we,
    input  logic [psim_pkg::CFG_ADDR_W-1:0]    i_cfg_addr,
    input  logic [psim_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    // Input item stream.
    input  logic                               i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    // tdata: out_coord_d0 [17:0], out_coord_d1 [35:18], out_coord_d2 [53:36], zero [55:54]
    input  logic [psim_pkg::IN_TDATA_W-1:0]    i_s_axis_tdata,
    // Result item stream.
    output logic                               o_m_axis_tvalid,
    input  logic                               i_m_axis_tready,
    // tdata: src_index [47:0]
    output logic [psim_pkg::OUT_TDATA_W-1:0]   o_m_axis_tdata,
    // tuser: use_fill [0], map_error [1]
    output logic [psim_pkg::OUT_TUSER_W-1:0]   o_m_axis_tuser
);
    import psim_pkg::*;

    t_pad_mode                          r_pad_mode;
    logic [MAX_DIMS-1:0][SIZE_W-1:0]    r_in_size;
    logic [MAX_DIMS-1:0][SIZE_W-1:0]    r_left_pad;
    logic                               r_v1;
    logic                               load1;
    logic                               take;
    t_lane_res [MAX_DIMS-1:0]           lane_res;
    logic [IDX_W-1:0]                   out_index;
    logic                               out_fill;
    logic                               out_err;

    // Register file. Writes to an index past the list fall into the default arm.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pad_mode <= MODE_CONSTANT;
            for (int d = 0; d < MAX_DIMS; d++) begin
                r_in_size[d]  <= SIZE_W'(1);
                r_left_pad[d] <= '0;
            end
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                REG_PAD_MODE:    r_pad_mode    <= t_pad_mode'(i_cfg_data[MODE_W-1:0]);
                REG_IN_SIZE_D0:  r_in_size[0]  <= i_cfg_data;
                REG_IN_SIZE_D1:  r_in_size[1]  <= i_cfg_data;
                REG_IN_SIZE_D2:  r_in_size[2]  <= i_cfg_data;
                REG_LEFT_PAD_D0: r_left_pad[0] <= i_cfg_data;
                REG_LEFT_PAD_D1: r_left_pad[1] <= i_cfg_data;
                REG_LEFT_PAD_D2: r_left_pad[2] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // The lane stage takes a new item whenever it is empty or its item moves on.
    assign o_s_axis_tready = !r_v1 || take;
    assign load1           = i_s_axis_tvalid && o_s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (load1) begin
            r_v1 <= 1'b1;
        end else if (take) begin
            r_v1 <= 1'b0;
        end
    end

    // One lane per dimension. Dimensions outside the used set contribute a
    // zero term and no flags.
    for (genvar d = 0; d < MAX_DIMS; d++) begin : g_lane
        if (d >= FIRST_DIM) begin : g_used
            psim_lane u_lane (
                .i_clk   (i_clk),
                .i_load  (load1),
                .i_coord (i_s_axis_tdata[d*IN_FIELD_W +: COORD_USE_W]),
                .i_mode  (r_pad_mode),
                .i_size  (r_in_size[d]),
                .i_lpad  (r_left_pad[d]),
                .o_res   (lane_res[d])
            );
        end else begin : g_unused
            assign lane_res[d] = '0;
        end
    end

    psim_merge u_merge (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_v1),
        .o_take  (take),
        .i_res   (lane_res),
        .i_size  (r_in_size),
        .o_valid (o_m_axis_tvalid),
        .i_ready (i_m_axis_tready),
        .o_index (out_index),
        .o_fill  (out_fill),
        .o_err   (out_err)
    );

    assign o_m_axis_tdata = out_index;
    assign o_m_axis_tuser = {out_err, out_fill};

endmodule

[rtl/core/psim_checker.sv]
// ---------------------------------------------------------------------------
// psim_checker
// Port-level checks of the pad source index mapper, bound to the top level.
// ---------------------------------------------------------------------------
`include "pad_source_index_mapper_macros.svh"

module psim_checker (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [psim_pkg::CFG_ADDR_W-1:0]    i_cfg_addr,
    input  logic [psim_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  logic                               i_s_axis_tvalid,
    input  logic                               o_s_axis_tready,
    input  logic [psim_pkg::IN_TDATA_W-1:0]    i_s_axis_tdata,
    input  logic                               o_m_axis_tvalid,
    input  logic                               i_m_axis_tready,
    input  logic [psim_pkg::OUT_TDATA_W-1:0]   o_m_axis_tdata,
    input  logic [psim_pkg::OUT_TUSER_W-1:0]   o_m_axis_tuser
);

    // A reset cycle leaves no result on the output.
    `PSIM_ASSERT_ALWAYS(a_reset_empty, !i_rst_n |=> !o_m_axis_tvalid, "output valid after reset")

    // Fill and error never come together.
    `PSIM_ASSERT(a_flags_excl, o_m_axis_tvalid |-> !(o_m_axis_tuser[0] && o_m_axis_tuser[1]), "fill and error both set")

    // A flagged item carries a zero index.
    `PSIM_ASSERT(a_flag_zero, o_m_axis_tvalid && (o_m_axis_tuser != 2'b00) |-> o_m_axis_tdata == '0, "flagged item with nonzero index")

    // A stalled result holds.
    `PSIM_ASSERT(a_stall_hold, o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser), "stalled result changed")

endmodule

bind pad_source_index_mapper psim_checker u_psim_checker (.*);

[tb/psim_tb_pkg.sv]
// ---------------------------------------------------------------------------
// psim_tb_pkg
// Scoreboard for the pad source index mapper: folds each accepted coordinate
// triple into the expected source index and flags, and checks the results.
// ---------------------------------------------------------------------------
package psim_tb_pkg;

    import psim_pkg::*;

    typedef enum {DIM_INSIDE, DIM_FILL, DIM_ERROR} dim_map_e;

    typedef struct {
        logic [IDX_W-1:0] index;
        logic             fill;
        logic             err;
    } src_lookup_t;

    class source_index_tracker;
        t_pad_mode         mode;
        logic [SIZE_W-1:0] extent [MAX_DIMS];
        logic [SIZE_W-1:0] lead   [MAX_DIMS];
        src_lookup_t       expected_sources [$];
        int                mismatches;

        function new();
            mode = MODE_CONSTANT;
            foreach (extent[d]) begin
                extent[d] = 1;
                lead[d]   = 0;
            end
            mismatches = 0;
        endfunction

        function void set_reg(logic [CFG_ADDR_W-1:0] addr, logic [CFG_DATA_W-1:0] data);
            case (addr)
                REG_PAD_MODE:    mode = t_pad_mode'(data[MODE_W-1:0]);
                REG_IN_SIZE_D0:  extent[0] = data;
                REG_IN_SIZE_D1:  extent[1] = data;
                REG_IN_SIZE_D2:  extent[2] = data;
                REG_LEFT_PAD_D0: lead[0] = data;
                REG_LEFT_PAD_D1: lead[1] = data;
                REG_LEFT_PAD_D2: lead[2] = data;
                default: ;
            endcase
        endfunction

        // Maps one output coordinate back into the input extent of dimension d.
        function dim_map_e fold_coord(logic [IN_FIELD_W-1:0] coord, int d, output longint src);
            longint x;
            longint l;
            longint s;
            longint m;
            longint e;
            x   = coord;
            l   = lead[d];
            s   = extent[d];
            src = 0;
            if (x < l) begin
                case (mode)
                    MODE_CONSTANT:  return DIM_FILL;
                    MODE_REFLECT:   m = l - x;
                    MODE_REPLICATE: m = 0;
                    default:        m = s - (l - x);
                endcase
            end else if (x >= l + s) begin
                e = x - (l + s);
                case (mode)
                    MODE_CONSTANT:  return DIM_FILL;
                    MODE_REFLECT:   m = s - REFLECT_GAP - e;
                    MODE_REPLICATE: m = s - 1;
                    default:        m = e;
                endcase
            end else begin
                m = x - l;
            end
            if (m < 0 || m >= s)
                return DIM_ERROR;
            src = m;
            return DIM_INSIDE;
        endfunction

        function void note_item(logic [IN_TDATA_W-1:0] tdata);
            logic [IN_FIELD_W-1:0] cmask;
            longint unsigned       index;
            longint unsigned       stride;
            longint                src;
            logic                  fill;
            logic                  err;
            src_lookup_t           r;
            cmask  = {IN_FIELD_W{1'b1}} >> (IN_FIELD_W - COORD_USE_W);
            index  = 0;
            stride = 1;
            fill   = 1'b0;
            err    = 1'b0;
            for (int d = MAX_DIMS - 1; d >= FIRST_DIM; d--) begin
                case (fold_coord(tdata[d*IN_FIELD_W +: IN_FIELD_W] & cmask, d, src))
                    DIM_FILL:  fill = 1'b1;
                    DIM_ERROR: err = 1'b1;
                    default:   index += longint'(src) * stride;
                endcase
                stride *= extent[d];
            end
            r.index = (fill || err) ? '0 : index[IDX_W-1:0];
            r.fill  = fill & ~err;
            r.err   = err;
            expected_sources.push_back(r);
        endfunction

        function int pending();
            return expected_sources.size();
        endfunction

        function void compare_result(logic [OUT_TDATA_W-1:0] tdata,
                                     logic [OUT_TUSER_W-1:0] tuser);
            src_lookup_t exp_r;
            if (expected_sources.size() == 0) begin
                $error("unexpected result: src_index %0h tuser %b", tdata, tuser);
                mismatches++;
                return;
            end
            exp_r = expected_sources.pop_front();
            if (tdata[IDX_W-1:0] !== exp_r.index) begin
                $error("src_index: expected %0h, got %0h", exp_r.index, tdata[IDX_W-1:0]);
                mismatches++;
            end
            if (tuser[0] !== exp_r.fill) begin
                $error("use_fill: expected %0b, got %0b", exp_r.fill, tuser[0]);
                mismatches++;
            end
            if (tuser[1] !== exp_r.err) begin
                $error("map_error: expected %0b, got %0b", exp_r.err, tuser[1]);
                mismatches++;
            end
        endfunction
    endclass

endpackage

[tb/pad_source_index_mapper_tb.sv]
// ---------------------------------------------------------------------------
// pad_source_index_mapper_tb
// Drives coordinate items through the pad source index mapper under several
// padding setups and checks every result against a scoreboard prediction.
// ---------------------------------------------------------------------------
module pad_source_index_mapper_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import psim_pkg::*;
    import psim_tb_pkg::*;

    // Index past the end of the register list; writes there must be dropped.
    localparam logic [CFG_ADDR_W-1:0] REG_UNMAPPED = 3'd7;
    localparam int COORD_MAX = (1 << IN_FIELD_W) - 1;
    localparam int SIZE_MAX  = (1 << SIZE_W) - 1;
    localparam int RANDOM_PHASES = 12;
    localparam int ITEMS_PER_PHASE = 33;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_cfg_we = 1'b0;
    logic [CFG_ADDR_W-1:0]  i_cfg_addr = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_data = '0;
    logic                   i_s_axis_tvalid = 1'b0;
    logic                   o_s_axis_tready;
    // tdata: out_coord_d0 [17:0], out_coord_d1 [35:18], out_coord_d2 [53:36], zero [55:54]
    logic [IN_TDATA_W-1:0]  i_s_axis_tdata = '0;
    logic                   o_m_axis_tvalid;
    logic                   i_m_axis_tready = 1'b0;
    // tdata: src_index [47:0]
    logic [OUT_TDATA_W-1:0] o_m_axis_tdata;
    // tuser: use_fill [0], map_error [1]
    logic [OUT_TUSER_W-1:0] o_m_axis_tuser;

    source_index_tracker sb = new();

    // Idling control shared between the sender and the receiver.
    bit quiet    = 1'b0;
    bit hold_req = 1'b0;

    // Current extents and pads, used to aim the random coordinates.
    int cur_size [MAX_DIMS];
    int cur_pad  [MAX_DIMS];

    pad_source_index_mapper u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_addr      (i_cfg_addr),
        .i_cfg_data      (i_cfg_data),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Results are sampled at the rising edge, before any nonblocking update lands.
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready)
            sb.compare_result(o_m_axis_tdata, o_m_axis_tuser);
    end

    // Receiver: random stall bursts, plus one long hold-off on request so that
    // the pipeline backs up and the input side has to stall.
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                i_m_axis_tready <= 1'b0;
                repeat (80) @(posedge i_clk);
                hold_req = 1'b0;
            end else if (!quiet && $urandom_range(0, 4) == 0) begin
                i_m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge i_clk);
            end else begin
                i_m_axis_tready <= 1'b1;
            end
        end
    end

    // Offers one coordinate item and returns at the edge where it is taken.
    // The valid is left high so back-to-back items stream without a bubble unless a random gap is drawn.
    task automatic send_coords(input int c0, input int c1, input int c2);
        if (!quiet && $urandom_range(0, 3) == 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {2'b00, c2[IN_FIELD_W-1:0], c1[IN_FIELD_W-1:0], c0[IN_FIELD_W-1:0]};
        do @(posedge i_clk); while (!o_s_axis_tready);
        sb.note_item(i_s_axis_tdata);
    endtask

    // Stops offering and waits for every outstanding result to drain.
    task automatic settle();
        i_s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr, input int data);
        i_cfg_we   <= 1'b1;
        i_cfg_addr <= addr;
        i_cfg_data <= data[CFG_DATA_W-1:0];
        @(posedge i_clk);
        sb.set_reg(addr, data[CFG_DATA_W-1:0]);
    endtask

    // Loads a full setup. Junk above the mode bits must be ignored, and the
    // unmapped index is hit now and then to confirm it changes nothing.
    task automatic load_setup(input t_pad_mode mode, input int s0, input int s1, input int s2,
                              input int p0, input int p1, input int p2);
        cur_size = '{s0, s1, s2};
        cur_pad  = '{p0, p1, p2};
        write_reg(REG_PAD_MODE, ($urandom_range(0, SIZE_MAX) & ~3) | int'(mode));
        write_reg(REG_IN_SIZE_D0, s0);
        write_reg(REG_IN_SIZE_D1, s1);
        write_reg(REG_IN_SIZE_D2, s2);
        write_reg(REG_LEFT_PAD_D0, p0);
        write_reg(REG_LEFT_PAD_D1, p1);
        write_reg(REG_LEFT_PAD_D2, p2);
        if ($urandom_range(0, 2) == 0)
            write_reg(REG_UNMAPPED, $urandom_range(0, SIZE_MAX));
        i_cfg_we <= 1'b0;
    endtask

    // Mostly lands near the pad regions of the dimension; sometimes anywhere.
    function automatic int pick_coord(input int d);
        int sel;
        int v;
        sel = $urandom_range(0, 9);
        if (sel < 7) begin
            v = $urandom_range(0, 2 * cur_pad[d] + cur_size[d] + 2);
            if (v > COORD_MAX)
                v = COORD_MAX;
        end else if (sel < 9) begin
            v = $urandom_range(0, COORD_MAX);
        end else begin
            v = $urandom_range(0, 1) ? COORD_MAX : 0;
        end
        return v;
    endfunction

    function automatic int pick_size();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0) return 0;
        if (r == 1) return SIZE_MAX;
        if (r == 2) return $urandom_range(0, SIZE_MAX);
        return $urandom_range(1, 12);
    endfunction

    function automatic int pick_pad();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0) return SIZE_MAX;
        if (r == 1) return $urandom_range(0, SIZE_MAX);
        return $urandom_range(0, 14);
    endfunction

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Register defaults: constant mode, unit sizes, no pads.
        send_coords(0, 0, 0);
        send_coords(1, 0, 0);
        send_coords(COORD_MAX, COORD_MAX, COORD_MAX);
        settle();

        // Every mode on one small shape: inside, left pad, first right pad
        // element, and far beyond the right edge.
        for (int m = 0; m < 4; m++) begin
            load_setup(t_pad_mode'(m), 4, 5, 6, 2, 1, 3);
            send_coords(3, 3, 7);
            send_coords(0, 0, 0);
            send_coords(6, 6, 9);
            send_coords(COORD_MAX, COORD_MAX, COORD_MAX);
            settle();
        end

        // Largest extents: the last inside element gives the top index, and
        // a circular wrap too far out must raise the error flag.
        load_setup(MODE_CIRCULAR, SIZE_MAX, SIZE_MAX, SIZE_MAX, SIZE_MAX, SIZE_MAX, SIZE_MAX);
        send_coords(2 * SIZE_MAX - 1, 2 * SIZE_MAX - 1, 2 * SIZE_MAX - 1);
        send_coords(SIZE_MAX, SIZE_MAX, SIZE_MAX);
        send_coords(COORD_MAX, COORD_MAX, COORD_MAX);
        settle();

        // Zero extent: a fill in constant mode, an error once it is mapped.
        load_setup(MODE_CONSTANT, 0, 0, 0, 0, 0, 0);
        send_coords(0, 0, 0);
        settle();
        load_setup(MODE_REPLICATE, 0, 0, 0, 0, 0, 0);
        send_coords(0, 0, 0);
        settle();

        // Random setups with coordinates aimed at the region boundaries.
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            load_setup(t_pad_mode'($urandom_range(0, 3)), pick_size(), pick_size(), pick_size(),
                       pick_pad(), pick_pad(), pick_pad());
            if (ph == 2)
                hold_req = 1'b1;
            if (ph >= RANDOM_PHASES - 2)
                quiet = 1'b1;
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
                send_coords(pick_coord(0), pick_coord(1), pick_coord(2));
            settle();
        end

        repeat (8) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("PASS pad_source_index_mapper");
        else
            $display("FAIL pad_source_index_mapper");
        $finish;
    end

    // Watchdog, far beyond the slowest legal run.
    initial begin
        #3000000;
        $display("FAIL pad_source_index_mapper");
        $finish;
    end

endmodule
